// ===== sv/gap_buffer_engine_core_macros.svh =====
// Assertion macros shared by the gap buffer engine checker
`ifndef GAP_BUFFER_ENGINE_CORE_MACROS_SVH
`define GAP_BUFFER_ENGINE_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define GBE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define GBE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gbe_pkg.sv =====
// Shared types, constants and codes of the gap buffer engine
package gbe_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 15;
    localparam int OP_W        = 3;
    localparam int CHAR_W      = 8;
    localparam int STAT_W      = 2;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_LEFT   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_RIGHT  = 3'd2;
    localparam logic [OP_W-1:0] OP_STEP_RIGHT = 3'd3;
    localparam logic [OP_W-1:0] OP_STEP_LEFT  = 3'd4;
    localparam logic [OP_W-1:0] OP_JUMP       = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STEP,
        ST_JUMP,
        ST_JUMP_MOVE
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_INS,
        PTR_DEL_L,
        PTR_DEL_R,
        PTR_MOVE_R,
        PTR_MOVE_L
    } ptr_op_t;

    typedef enum logic {
        DIR_RIGHT,
        DIR_LEFT
    } dir_t;

    typedef enum logic {
        WR_CHAR,
        WR_RDATA
    } wr_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic              ld_in;
        logic              rd_en;
        logic              wr_en;
        dir_t              dir;
        wr_sel_t           wr_sel;
        ptr_op_t           ptr_op;
        logic              res_load;
        logic [STAT_W-1:0] res_status;
        logic              res_use_rdata;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            left_empty;
        logic            right_empty;
        logic            bad_target;
        logic            need_right;
        logic            need_left;
        logic            out_free;
    } stat_t;

endpackage

// ===== sv/gbe_datapath.sv =====
// Gap buffer datapath: byte store, gap pointers, request and result registers
module gbe_datapath
    import gbe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [CHAR_W-1:0] s_char_in,
    input  logic [POS_W-1:0]  s_target_pos,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [CHAR_W-1:0] m_char_out,
    output logic [POS_W-1:0]  m_cursor_pos,
    output logic [POS_W-1:0]  m_data_size
);

    logic [CHAR_W-1:0] store_mem [STORE_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [POS_W-1:0]  target_reg;

    // gap begin, and gap end plus one (ranges 0 .. STORE_DEPTH)
    logic [POS_W-1:0]  gb_reg, gb_next;
    logic [POS_W-1:0]  ge1_reg, ge1_next;

    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] res_status_reg;
    logic [CHAR_W-1:0] res_char_reg;
    logic [POS_W-1:0]  res_cursor_reg;
    logic [POS_W-1:0]  res_size_reg;

    logic [POS_W-1:0]  size_cur, size_next;
    logic [POS_W-1:0]  gb_dec, ge1_dec;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [CHAR_W-1:0] wr_data;

    // Latch the request beat
    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            op_reg     <= s_operation;
            char_reg   <= s_char_in;
            target_reg <= s_target_pos;
        end
    end

    assign gb_dec  = gb_reg - POS_W'(1);
    assign ge1_dec = ge1_reg - POS_W'(1);

    // Data size now and after the pointer update
    assign size_cur  = gb_reg + POS_W'(STORE_DEPTH) - ge1_reg;
    assign size_next = gb_next + POS_W'(STORE_DEPTH) - ge1_next;

    // Advance the gap pointers
    always_comb begin
        gb_next  = gb_reg;
        ge1_next = ge1_reg;
        unique case (cmd.ptr_op)
            PTR_INS: begin
                gb_next = gb_reg + POS_W'(1);
            end
            PTR_DEL_L: begin
                gb_next = gb_dec;
            end
            PTR_DEL_R: begin
                ge1_next = ge1_reg + POS_W'(1);
            end
            PTR_MOVE_R: begin
                gb_next  = gb_reg + POS_W'(1);
                ge1_next = ge1_reg + POS_W'(1);
            end
            PTR_MOVE_L: begin
                gb_next  = gb_dec;
                ge1_next = ge1_dec;
            end
            default: begin
                gb_next  = gb_reg;
                ge1_next = ge1_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gb_reg  <= '0;
            ge1_reg <= POS_W'(STORE_DEPTH);
        end else begin
            gb_reg  <= gb_next;
            ge1_reg <= ge1_next;
        end
    end

    // Store addressing: read the byte beside the gap, write it on the other side
    assign rd_addr = (cmd.dir == DIR_RIGHT) ? ge1_reg[ADDR_W-1:0] : gb_dec[ADDR_W-1:0];
    assign wr_addr = (cmd.wr_sel == WR_CHAR || cmd.dir == DIR_RIGHT) ? gb_reg[ADDR_W-1:0]
                                                                       : ge1_dec[ADDR_W-1:0];
    assign wr_data = (cmd.wr_sel == WR_CHAR) ? char_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Hold the result beat until taken
    assign m_valid_next = cmd.res_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_char_reg   <= cmd.res_use_rdata ? rd_data_reg : '0;
            res_cursor_reg <= gb_next;
            res_size_reg   <= size_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = res_status_reg;
    assign m_char_out   = res_char_reg;
    assign m_cursor_pos = res_cursor_reg;
    assign m_data_size  = res_size_reg;

    // Status flags for the controller
    assign stat.op          = op_reg;
    assign stat.full        = !(ge1_reg > gb_reg);
    assign stat.left_empty  = (gb_reg == '0);
    assign stat.right_empty = (ge1_reg == POS_W'(STORE_DEPTH));
    assign stat.bad_target  = (target_reg > size_cur);
    assign stat.need_right  = (gb_reg < target_reg);
    assign stat.need_left   = (gb_reg > target_reg);
    assign stat.out_free    = !m_valid_reg || m_ready;

endmodule

// ===== sv/gbe_ctrl.sv =====
// Gap buffer controller: sequences each request over the datapath
module gbe_ctrl
    import gbe_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            // Take a request beat
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.ld_in  = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end

            // Decode: finish inserts, deletes, unused and failed requests, or start a step's store read or a jump walk
            ST_EXEC: begin
                unique case (stat.op)
                    OP_INSERT: begin
                        if (stat.out_free) begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                            if (stat.full) begin
                                cmd.res_status = STAT_FULL;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = WR_CHAR;
                                cmd.ptr_op = PTR_INS;
                            end
                        end
                    end
                    OP_DEL_LEFT: begin
                        if (stat.out_free) begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                            if (stat.left_empty) begin
                                cmd.res_status = STAT_EMPTY;
                            end else begin
                                cmd.ptr_op = PTR_DEL_L;
                            end
                        end
                    end
                    OP_DEL_RIGHT: begin
                        if (stat.out_free) begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                            if (stat.right_empty) begin
                                cmd.res_status = STAT_EMPTY;
                            end else begin
                                cmd.ptr_op = PTR_DEL_R;
                            end
                        end
                    end
                    OP_STEP_RIGHT: begin
                        if (!stat.right_empty) begin
                            cmd.rd_en  = 1'b1;
                            cmd.dir    = DIR_RIGHT;
                            state_next = ST_STEP;
                        end else if (stat.out_free) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STAT_EMPTY;
                            state_next     = ST_IDLE;
                        end
                    end
                    OP_STEP_LEFT: begin
                        if (!stat.left_empty) begin
                            cmd.rd_en  = 1'b1;
                            cmd.dir    = DIR_LEFT;
                            state_next = ST_STEP;
                        end else if (stat.out_free) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STAT_EMPTY;
                            state_next     = ST_IDLE;
                        end
                    end
                    OP_JUMP: begin
                        if (!stat.bad_target) begin
                            state_next = ST_JUMP;
                        end else if (stat.out_free) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STAT_BADPOS;
                            state_next     = ST_IDLE;
                        end
                    end
                    default: begin
                        // unused selector: report ok, change nothing
                        if (stat.out_free) begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                endcase
            end

            // Write the read byte across the gap and report it
            ST_STEP: begin
                if (stat.out_free) begin
                    cmd.wr_en         = 1'b1;
                    cmd.wr_sel        = WR_RDATA;
                    cmd.dir           = (stat.op == OP_STEP_RIGHT) ? DIR_RIGHT : DIR_LEFT;
                    cmd.ptr_op        = (stat.op == OP_STEP_RIGHT) ? PTR_MOVE_R : PTR_MOVE_L;
                    cmd.res_load      = 1'b1;
                    cmd.res_use_rdata = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            // Walk toward the target one byte at a time
            ST_JUMP: begin
                if (stat.need_right && !stat.right_empty) begin
                    cmd.rd_en  = 1'b1;
                    cmd.dir    = DIR_RIGHT;
                    state_next = ST_JUMP_MOVE;
                end else if (stat.need_left && !stat.left_empty) begin
                    cmd.rd_en  = 1'b1;
                    cmd.dir    = DIR_LEFT;
                    state_next = ST_JUMP_MOVE;
                end else if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_JUMP_MOVE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_RDATA;
                cmd.dir    = stat.need_right ? DIR_RIGHT : DIR_LEFT;
                cmd.ptr_op = stat.need_right ? PTR_MOVE_R : PTR_MOVE_L;
                state_next = ST_JUMP;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/gap_buffer_engine_core.sv =====
// Gap buffer engine top level: controller plus datapath
//
//  channel  | ports                                             | dir
//  ---------+---------------------------------------------------+-----
//  request  | s_valid s_ready s_operation s_char_in s_target_pos| in
//  result   | m_valid m_ready m_status m_char_out m_cursor_pos   | out
//           | m_data_size                                       |
//
// Insert, delete, failed and unused requests are accepted, then executed.
// A step reads the single-port store in ST_EXEC, then writes it in ST_STEP.
// A jump moves bytes one at a time, with one read and one write for each.
// A finished result sits in an output register; the next beat is accepted
// while it waits, and the controller holds only when a second result is due.
// aresetn is synchronous; it empties the text, the store itself keeps no reset.
module gap_buffer_engine_core
    import gbe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [CHAR_W-1:0] s_char_in,
    input  logic [POS_W-1:0]  s_target_pos,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [CHAR_W-1:0] m_char_out,
    output logic [POS_W-1:0]  m_cursor_pos,
    output logic [POS_W-1:0]  m_data_size
);

    cmd_t  cmd;
    stat_t stat;

    gbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gbe_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_operation  (s_operation),
        .s_char_in    (s_char_in),
        .s_target_pos (s_target_pos),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_char_out   (m_char_out),
        .m_cursor_pos (m_cursor_pos),
        .m_data_size  (m_data_size)
    );

endmodule

// ===== sv/gbe_checker.sv =====
// Port-level checks of the gap buffer engine and their bind
`include "gap_buffer_engine_core_macros.svh"

module gbe_checker
    import gbe_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [STAT_W-1:0] m_status,
    input logic [CHAR_W-1:0] m_char_out,
    input logic [POS_W-1:0]  m_cursor_pos,
    input logic [POS_W-1:0]  m_data_size
);

    // A stalled result beat holds
    `GBE_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_status, m_char_out, m_cursor_pos, m_data_size}), "result beat changed while stalled")

    // The cursor never lies beyond the text, nor the text beyond the store
    `GBE_ASSERT_SAME(a_cursor_in_text, aclk, aresetn, m_valid, m_cursor_pos <= m_data_size && m_data_size <= POS_W'(STORE_DEPTH), "cursor or size out of range")

    // Full is reported only with the store full
    `GBE_ASSERT_SAME(a_full_size, aclk, aresetn, m_valid && m_status == STAT_FULL, m_data_size == POS_W'(STORE_DEPTH), "full status with room left")

    // A failed request passes no byte
    `GBE_ASSERT_SAME(a_fail_no_char, aclk, aresetn, m_valid && m_status != STAT_OK, m_char_out == '0, "byte returned on a failed request")

endmodule

bind gap_buffer_engine_core gbe_checker u_gbe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_char_out   (m_char_out),
    .m_cursor_pos (m_cursor_pos),
    .m_data_size  (m_data_size)
);

// ===== tb/gap_buffer_edit_checker.sv =====
// Request/result watcher for the gap buffer engine: predicts each result and compares it
module gap_buffer_edit_checker
    import gbe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [CHAR_W-1:0] s_char_in,
    input  logic [POS_W-1:0]  s_target_pos,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [STAT_W-1:0] m_status,
    input  logic [CHAR_W-1:0] m_char_out,
    input  logic [POS_W-1:0]  m_cursor_pos,
    input  logic [POS_W-1:0]  m_data_size,
    output int                fail_count,
    output int                outstanding,
    output int                text_len,
    output int                cursor_at
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CHAR_W-1:0] char_out;
        logic [POS_W-1:0]  cursor;
        logic [POS_W-1:0]  size;
    } edit_result_t;

    // Shadow text store and gap bounds
    logic [CHAR_W-1:0] text_mem [STORE_DEPTH];
    int gap_first;
    int gap_last;   // drops to -1 when the store is full and the cursor sits at 0
    int errors = 0;
    edit_result_t due_results [$];

    function automatic int held_bytes();
        return gap_first + (STORE_DEPTH - 1 - gap_last);
    endfunction

    // Move one byte from right of the gap to its left
    function automatic logic [CHAR_W-1:0] pull_right();
        logic [CHAR_W-1:0] b;
        gap_last++;
        b = text_mem[gap_last];
        text_mem[gap_first] = b;
        gap_first++;
        return b;
    endfunction

    // Move one byte from left of the gap to its right
    function automatic logic [CHAR_W-1:0] push_left();
        logic [CHAR_W-1:0] b;
        gap_first--;
        b = text_mem[gap_first];
        text_mem[gap_last] = b;
        gap_last--;
        return b;
    endfunction

    // Apply one request to the shadow state and build its result
    function automatic edit_result_t apply_edit(input logic [OP_W-1:0]   op,
                                                input logic [CHAR_W-1:0] ch,
                                                input logic [POS_W-1:0]  tgt);
        edit_result_t res;
        int target;
        int held;
        res = '0;
        res.status = STAT_OK;
        target = int'(tgt);
        case (op)
            OP_INSERT: begin
                if (gap_last >= gap_first) begin
                    text_mem[gap_first] = ch;
                    gap_first++;
                end else begin
                    res.status = STAT_FULL;
                end
            end
            OP_DEL_LEFT: begin
                if (gap_first == 0) res.status = STAT_EMPTY;
                else gap_first--;
            end
            OP_DEL_RIGHT: begin
                if (gap_last >= STORE_DEPTH - 1) res.status = STAT_EMPTY;
                else gap_last++;
            end
            OP_STEP_RIGHT: begin
                if (gap_last >= STORE_DEPTH - 1) res.status = STAT_EMPTY;
                else res.char_out = pull_right();
            end
            OP_STEP_LEFT: begin
                if (gap_first == 0) res.status = STAT_EMPTY;
                else res.char_out = push_left();
            end
            OP_JUMP: begin
                if (target > held_bytes()) begin
                    res.status = STAT_BADPOS;
                end else begin
                    while (gap_first < target && gap_last < STORE_DEPTH - 1)
                        void'(pull_right());
                    while (gap_first > target && gap_first > 0)
                        void'(push_left());
                end
            end
            default: ;
        endcase
        held = held_bytes();
        res.cursor = gap_first[POS_W-1:0];
        res.size = held[POS_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string label, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Compare result beats, then queue the prediction for a request beat
    always @(posedge aclk) begin
        edit_result_t want;
        if (!aresetn) begin
            gap_first = 0;
            gap_last = STORE_DEPTH - 1;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual status %0d",
                             $time, m_status);
                end else begin
                    want = due_results.pop_front();
                    check_field("status", POS_W'(want.status), POS_W'(m_status));
                    check_field("char_out", POS_W'(want.char_out), POS_W'(m_char_out));
                    check_field("cursor_pos", want.cursor, m_cursor_pos);
                    check_field("data_size", want.size, m_data_size);
                end
            end
            if (s_valid && s_ready)
                due_results.push_back(apply_edit(s_operation, s_char_in, s_target_pos));
        end
        fail_count <= errors;
        outstanding <= due_results.size();
        text_len <= held_bytes();
        cursor_at <= gap_first;
    end

endmodule

// ===== tb/gap_buffer_engine_core_test.sv =====
// Testbench top for the gap buffer engine: clock, reset, request and result drivers, verdict
module gap_buffer_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gbe_pkg::*;

    localparam int          RANDOM_EDITS = 710;
    localparam int          PHASE_LEN    = 60;
    localparam int          TAIL_CYCLES  = 16;
    localparam int unsigned RUN_LIMIT_NS = 50_000_000;

    // Selector codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [OP_W-1:0]   s_operation;
    logic [CHAR_W-1:0] s_char_in;
    logic [POS_W-1:0]  s_target_pos;
    logic              m_valid;
    logic              m_ready;
    logic [STAT_W-1:0] m_status;
    logic [CHAR_W-1:0] m_char_out;
    logic [POS_W-1:0]  m_cursor_pos;
    logic [POS_W-1:0]  m_data_size;

    int fail_count;
    int outstanding;
    int text_len;
    int cursor_at;

    // Percent chance of an idle burst before each beat, per side
    int send_odds = 0;
    int take_odds = 0;

    gap_buffer_engine_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_char_in    (s_char_in),
        .s_target_pos (s_target_pos),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_char_out   (m_char_out),
        .m_cursor_pos (m_cursor_pos),
        .m_data_size  (m_data_size)
    );

    gap_buffer_edit_checker edit_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_char_in    (s_char_in),
        .s_target_pos (s_target_pos),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_char_out   (m_char_out),
        .m_cursor_pos (m_cursor_pos),
        .m_data_size  (m_data_size),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .text_len     (text_len),
        .cursor_at    (cursor_at)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int pick_odds();
        case ($urandom_range(2))
            0: return 0;
            1: return 12;
            default: return 40;
        endcase
    endfunction

    // Drive one request beat and hold it until accepted
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [POS_W-1:0] tgt);
        if (send_odds != 0 && $urandom_range(99) < send_odds) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_char_in <= ch;
        s_target_pos <= tgt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Pick one random request, steering the text length to stay moderate
    task automatic random_edit(output bit counted);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] tgt;
        int ins_pct;
        int pick;
        int len;
        len = text_len;
        ins_pct = (len < 24) ? 45 : (len > 160) ? 10 : 28;
        tgt = POS_W'($urandom_range(32767));
        if ($urandom_range(99) < ins_pct) begin
            op = OP_INSERT;
        end else begin
            pick = $urandom_range(99);
            if (pick < 2) op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
            else if (pick < 20) op = OP_DEL_LEFT;
            else if (pick < 38) op = OP_DEL_RIGHT;
            else if (pick < 60) op = OP_STEP_RIGHT;
            else if (pick < 82) op = OP_STEP_LEFT;
            else begin
                op = OP_JUMP;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: tgt = POS_W'($urandom_range(len));
                    6: tgt = POS_W'(cursor_at);
                    7: tgt = POS_W'(len + $urandom_range(1, 3));
                    8: ;    // keep the full-width value, mostly past the end
                    default: tgt = ($urandom_range(1) == 0) ? '0 : POS_W'(len);
                endcase
            end
        end
        counted = (op <= OP_JUMP);
        send_request(op, CHAR_W'($urandom_range(255)), tgt);
    endtask

    // Result side: ready with random stall bursts
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (take_odds != 0 && $urandom_range(99) < take_odds) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        int  edits;
        int  beats;
        bit  counted;
        s_valid <= 1'b0;
        s_operation <= OP_INSERT;
        s_char_in <= '0;
        s_target_pos <= '0;
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty buffer: every side is empty, jumps past the end fail
        send_request(OP_DEL_LEFT, 8'h00, '0);
        send_request(OP_DEL_RIGHT, 8'hFF, '1);
        send_request(OP_STEP_RIGHT, 8'h00, '0);
        send_request(OP_STEP_LEFT, 8'hFF, '1);
        send_request(OP_JUMP, 8'h00, 15'd0);
        send_request(OP_JUMP, 8'h00, 15'd1);
        send_request(OP_JUMP, 8'h00, 15'd16384);
        send_request(OP_SPARE_A, 8'hFF, '1);
        send_request(OP_SPARE_B, 8'h00, '0);

        // Small text: steps, jumps to both ends and the middle, deletes
        send_request(OP_INSERT, 8'h00, '1);
        send_request(OP_INSERT, 8'hFF, '0);
        send_request(OP_INSERT, 8'hA5, '0);
        send_request(OP_INSERT, 8'h5A, '0);
        send_request(OP_STEP_LEFT, 8'h00, '0);
        send_request(OP_STEP_LEFT, 8'h00, '0);
        send_request(OP_STEP_RIGHT, 8'h00, '0);
        send_request(OP_JUMP, 8'h00, 15'd0);
        send_request(OP_JUMP, 8'h00, 15'd4);
        send_request(OP_JUMP, 8'h00, 15'd2);
        send_request(OP_DEL_RIGHT, 8'h00, '0);
        send_request(OP_DEL_LEFT, 8'h00, '0);
        send_request(OP_JUMP, 8'h00, 15'd3);
        send_request(OP_INSERT, 8'h3C, '0);
        send_request(OP_JUMP, 8'h00, 15'h7FFF);

        // Random edits, idling odds re-chosen every phase
        edits = 0;
        beats = 0;
        while (edits < RANDOM_EDITS) begin
            if (beats % PHASE_LEN == 0) begin
                send_odds = pick_odds();
                take_odds = pick_odds();
            end
            random_edit(counted);
            beats++;
            if (counted) edits++;
        end

        // Back-to-back tail: work both ends of the text, jumps past the end
        send_odds = 0;
        take_odds = 0;
        send_request(OP_STEP_RIGHT, 8'h00, '0);
        send_request(OP_DEL_RIGHT, 8'h00, '0);
        send_request(OP_JUMP, 8'h00, 15'd16385);
        send_request(OP_JUMP, 8'h00, 15'd16384);
        send_request(OP_JUMP, 8'h00, 15'd0);
        send_request(OP_INSERT, 8'hC3, '0);
        send_request(OP_STEP_LEFT, 8'h00, '0);
        send_request(OP_DEL_LEFT, 8'h00, '0);
        send_request(OP_STEP_RIGHT, 8'h00, '0);
        send_request(OP_JUMP, 8'h00, 15'd16384);
        send_request(OP_DEL_LEFT, 8'h00, '0);
        send_request(OP_INSERT, 8'hFF, '0);
        send_request(OP_JUMP, 8'h00, 15'd0);
        send_request(OP_DEL_RIGHT, 8'h00, '0);
        send_request(OP_INSERT, 8'h81, '0);
        s_valid <= 1'b0;

        // Drain the result queue, then let any late beat show up
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
